### rtl/tgf_pkg.sv
// ----------------------------------------------------------------------------
// tgf_pkg: shared types for the track gap linear fill block
// transaction payloads, divider status and sequencer state encoding
// ----------------------------------------------------------------------------
`default_nettype none

package tgf_pkg;

   localparam int TRACK_W = 6;
   localparam int FIELD_W = 16;
   localparam int GAP_W   = 6;

   typedef struct packed {
      logic [TRACK_W-1:0] track_id;
      logic [FIELD_W-1:0] point_x;
      logic [FIELD_W-1:0] point_y;
      logic               final_frame;
   } req_type;

   typedef struct packed {
      logic [TRACK_W-1:0] out_track;
      logic [FIELD_W-1:0] out_x;
      logic [FIELD_W-1:0] out_y;
      logic               was_filled;
      logic               gap_overflow;
      logic               run_last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_EVAL,
      ST_HOLD,
      ST_MUL,
      ST_DIV,
      ST_EMIT,
      ST_LAST
   } tgf_state_type;

endpackage

`default_nettype wire

### rtl/track_gap_linear_fill_top.sv
// ----------------------------------------------------------------------------
// track_gap_linear_fill_top: per-track missing sample gap filler
// holds back missing samples and fills them by hold, by copy of the next sample or by linear interpolation
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_ready | req_data (req_type)
//  rsp_    | out       | rsp_valid/rsp_ready | rsp_data (rsp_type)
//
//  a transaction looks up the track in the read and evaluate states; held or
//  copied points go out directly, and interpolated points go through the
//  single shared divider, which serves x then y
//  req_ready is high only while the sequencer is idle
//  reset clears all track state at once through per-track valid flags
//  results stall in the output register while rsp_ready is low
// ----------------------------------------------------------------------------
`default_nettype none

module track_gap_linear_fill_top
   import tgf_pkg::*;
#(
   parameter int NUM_TRACKS = 64,
   parameter int MAX_GAP    = 63,
   parameter int COORD_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);

   localparam int DEPTH = (NUM_TRACKS < (1 << TRACK_W)) ? NUM_TRACKS : (1 << TRACK_W);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int NW    = CW + GAP_W;
   localparam int EW    = 2 * CW + GAP_W + 1;
   localparam logic [TRACK_W:0] DEPTH_L = (TRACK_W + 1)'(DEPTH);
   localparam logic [GAP_W-1:0] MAX_GAP_L = GAP_W'(MAX_GAP);

   tgf_state_type    state_ff, state_in;

   logic [TRACK_W-1:0] trk_ff, trk_in;
   logic [CW-1:0]      px_ff, px_in;
   logic [CW-1:0]      py_ff, py_in;
   logic               fin_ff, fin_in;
   logic [CW-1:0]      ax_ff, ax_in;
   logic [CW-1:0]      ay_ff, ay_in;
   logic               seen_ff, seen_in;
   logic [GAP_W-1:0]   len_ff, len_in;
   logic [GAP_W-1:0]   i_ff, i_in;
   logic               ovf_ff, ovf_in;
   logic               ysel_ff, ysel_in;
   logic [CW-1:0]      qx_ff, qx_in;
   logic [CW-1:0]      qy_ff, qy_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [EW-1:0]      ram_wr_data;
   logic               ram_rd_en;
   logic [EW-1:0]      ram_rd_data;
   logic [AW-1:0]      trk_addr;

   logic [EW-1:0]      ent;
   logic [CW-1:0]      e_ax, e_ay;
   logic [GAP_W-1:0]   e_gap, gap_inc;
   logic               e_seen;
   logic               missing, flush, last_i, out_free, in_range;

   logic               div_start;
   div_sts_type        div_sts;
   logic [CW-1:0]      div_quo;
   logic [NW-1:0]      div_num;
   logic [GAP_W:0]     den;
   logic [GAP_W-1:0]   w_a, w_b;
   logic [CW-1:0]      mul_a, mul_b;
   logic               rsp_load;
   rsp_type            rsp_word;

   assign in_range = {1'b0, req_data.track_id} < DEPTH_L;
   assign trk_addr = trk_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ent     = valid_ff[trk_addr] ? ram_rd_data : '0;
      e_ax    = ent[CW-1:0];
      e_ay    = ent[2*CW-1:CW];
      e_gap   = ent[2*CW+GAP_W-1:2*CW];
      e_seen  = ent[EW-1];
      gap_inc = e_gap + GAP_W'(1);
      missing = (px_ff == '0);
      flush   = fin_ff || (gap_inc >= MAX_GAP_L);
      last_i  = (i_ff == (len_ff - GAP_W'(1)));
   end

   // interpolation weights and numerator, rounded half up
   always_comb begin
      w_a     = len_ff - i_ff;
      w_b     = i_ff + GAP_W'(1);
      den     = {1'b0, len_ff} + (GAP_W + 1)'(1);
      mul_a   = ysel_ff ? ay_ff : ax_ff;
      mul_b   = ysel_ff ? py_ff : px_ff;
      div_num = NW'(mul_a) * NW'(w_a) + NW'(mul_b) * NW'(w_b) + NW'(den >> 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && in_range) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (missing) begin
               state_in = flush ? ST_HOLD : ST_IDLE;
            end else if (e_gap == '0) begin
               state_in = ST_LAST;
            end else begin
               state_in = e_seen ? ST_MUL : ST_EMIT;
            end
         end
         ST_HOLD: begin
            if (out_free && last_i) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               state_in = ysel_ff ? ST_EMIT : ST_MUL;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (last_i) begin
                  state_in = ST_LAST;
               end else begin
                  state_in = seen_ff ? ST_MUL : ST_EMIT;
               end
            end
         end
         ST_LAST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      trk_in      = trk_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      fin_in      = fin_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      seen_in     = seen_ff;
      len_in      = len_ff;
      i_in        = i_ff;
      ovf_in      = ovf_ff;
      ysel_in     = ysel_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      valid_in    = valid_ff;
      ram_wr_en   = 1'b0;
      ram_wr_data = {e_seen, e_gap, e_ay, e_ax};
      ram_rd_en   = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      rsp_word    = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               trk_in    = req_data.track_id;
               px_in     = req_data.point_x[CW-1:0];
               py_in     = req_data.point_y[CW-1:0];
               fin_in    = req_data.final_frame;
               ram_rd_en = in_range;
            end
         end
         ST_EVAL: begin
            seen_in = e_seen;
            ax_in   = e_seen ? e_ax : '0;
            ay_in   = e_seen ? e_ay : '0;
            i_in    = '0;
            ysel_in = 1'b0;
            ovf_in  = !fin_ff;
            if (missing) begin
               len_in      = gap_inc;
               ram_wr_data = flush ? {e_seen, {GAP_W{1'b0}}, e_ay, e_ax}
                                   : {e_seen, gap_inc, e_ay, e_ax};
            end else begin
               len_in      = e_gap;
               ram_wr_data = {1'b1, {GAP_W{1'b0}}, py_ff, px_ff};
            end
            ram_wr_en          = !fin_ff;
            valid_in[trk_addr] = !fin_ff;
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_word.out_track    = trk_ff;
               rsp_word.out_x        = FIELD_W'(ax_ff);
               rsp_word.out_y        = FIELD_W'(ay_ff);
               rsp_word.was_filled   = 1'b1;
               rsp_word.gap_overflow = ovf_ff;
               rsp_word.run_last     = last_i;
               i_in                  = i_ff + GAP_W'(1);
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (ysel_ff) begin
                  qy_in   = div_quo;
                  ysel_in = 1'b0;
               end else begin
                  qx_in   = div_quo;
                  ysel_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_word.out_track    = trk_ff;
               rsp_word.out_x        = FIELD_W'(seen_ff ? qx_ff : px_ff);
               rsp_word.out_y        = FIELD_W'(seen_ff ? qy_ff : py_ff);
               rsp_word.was_filled   = 1'b1;
               rsp_word.gap_overflow = 1'b0;
               rsp_word.run_last     = 1'b0;
               i_in                  = i_ff + GAP_W'(1);
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_word.out_track    = trk_ff;
               rsp_word.out_x        = FIELD_W'(px_ff);
               rsp_word.out_y        = FIELD_W'(py_ff);
               rsp_word.was_filled   = 1'b0;
               rsp_word.gap_overflow = 1'b0;
               rsp_word.run_last     = 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      rsp_data_in  = rsp_load ? rsp_word : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ysel_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ysel_ff      <= ysel_in;
      end
   end

   always_ff @(posedge clock) begin
      trk_ff      <= trk_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      fin_ff      <= fin_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      seen_ff     <= seen_in;
      len_ff      <= len_in;
      i_ff        <= i_in;
      ovf_ff      <= ovf_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rsp_data_ff <= rsp_data_in;
   end

   tgf_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (trk_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_data.track_id[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   tgf_div #(
      .CW (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_DIV))
      else $error("divider result outside divide state");

   a_point_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD || state_ff == ST_EMIT) |-> (i_ff < len_ff))
      else $error("point index beyond gap length");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> ($past(state_ff) == ST_RD))
      else $error("track lookup without read");
`endif

endmodule

`default_nettype wire

### rtl/tgf_ram.sv
// ----------------------------------------------------------------------------
// tgf_ram: generic single-port-write, single-port-read RAM
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tgf_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/tgf_div.sv
// ----------------------------------------------------------------------------
// tgf_div: shared radix-2 restoring divider
// one quotient bit per cycle; the quotient is known to fit in CW bits
// ----------------------------------------------------------------------------
`default_nettype none

module tgf_div
   import tgf_pkg::*;
#(
   parameter int CW = 16,
   localparam int NW = CW + GAP_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NW-1:0]     num,
   input  wire logic [GAP_W:0]    den,
   output div_sts_type            sts,
   output logic      [CW-1:0]     quo
);

   localparam int CNT_W = $clog2(CW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [GAP_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]    qn_ff, qn_in;

   logic [GAP_W:0]   trial;
   logic [GAP_W:0]   diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, qn_ff[CW-1]};
      ge    = (trial >= den);
      diff  = trial - den;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qn_in   = qn_ff;
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(CW);
         rem_in  = num[NW-1:CW];
         qn_in   = num[CW-1:0];
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         rem_in = ge ? diff[GAP_W-1:0] : trial[GAP_W-1:0];
         qn_in  = {qn_ff[CW-2:0], ge};
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      qn_ff  <= qn_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = qn_ff;

endmodule

`default_nettype wire
